/* rtl/assert_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Types, constants and codes shared by the sorted priority queue modules.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int TAG_BITS      = 64;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    localparam int CMD_W   = 3;
    localparam int TAG_W   = 64;
    localparam int PRI_W   = 16;
    localparam int STAT_W  = 3;
    localparam int ENTRY_W = 5;

    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_URGENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD    = 2'd0;
    localparam op_t OP_INSERT  = 2'd1;
    localparam op_t OP_DEQUEUE = 2'd2;
    localparam op_t OP_REMOVE  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [TAG_W-1:0] value_tag;
        logic [PRI_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [TAG_W-1:0]   out_tag;
        logic [PRI_W-1:0]   out_priority;
        logic               out_valid;
        logic [ENTRY_W-1:0] entry_count;
        logic               is_empty;
    } res_t;

    typedef struct packed {
        logic                     ahead;
        logic                     seen;
        logic [PRIORITY_BITS-1:0] hit_pri;
    } link_t;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
// One cell of the sorted row: holds one entry and shifts it left or right.
`default_nettype none

module spq_cell (
    input  wire logic                              clk,
    input  wire spq_pkg::op_t                      op,
    input  wire logic                              occupied,
    input  wire logic [spq_pkg::TAG_BITS-1:0]      key_tag,
    input  wire logic [spq_pkg::PRIORITY_BITS-1:0] key_pri,
    input  wire logic [spq_pkg::TAG_BITS-1:0]      left_tag,
    input  wire logic [spq_pkg::PRIORITY_BITS-1:0] left_pri,
    input  wire logic [spq_pkg::TAG_BITS-1:0]      right_tag,
    input  wire logic [spq_pkg::PRIORITY_BITS-1:0] right_pri,
    input  wire spq_pkg::link_t                    link_in,
    output spq_pkg::link_t                         link_out,
    output logic [spq_pkg::TAG_BITS-1:0]           tag,
    output logic [spq_pkg::PRIORITY_BITS-1:0]      pri
);
    import spq_pkg::*;

    logic [TAG_BITS-1:0]      tag_reg;
    logic [TAG_BITS-1:0]      tag_next;
    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [PRIORITY_BITS-1:0] pri_next;
    logic                     match;
    logic                     goes_before;
    logic                     from_right;

    // The new key belongs in front of this entry, or this cell is free.
    assign goes_before = !occupied || (pri_reg > key_pri) ||
                         ((pri_reg == key_pri) && (key_tag < tag_reg));
    assign match       = occupied && (tag_reg == key_tag);
    assign from_right  = (op == OP_DEQUEUE) ||
                         ((op == OP_REMOVE) && (link_in.seen || match));

    assign link_out.ahead   = goes_before;
    assign link_out.seen    = link_in.seen || match;
    assign link_out.hit_pri = (match && !link_in.seen) ? pri_reg : link_in.hit_pri;

    always_comb
    begin
        tag_next = tag_reg;
        pri_next = pri_reg;
        unique case (op)
            OP_INSERT:
            begin
                if (goes_before)
                begin
                    if (link_in.ahead)
                    begin
                        tag_next = left_tag;
                        pri_next = left_pri;
                    end
                    else
                    begin
                        tag_next = key_tag;
                        pri_next = key_pri;
                    end
                end
            end
            OP_DEQUEUE, OP_REMOVE:
            begin
                if (from_right)
                begin
                    tag_next = right_tag;
                    pri_next = right_pri;
                end
            end
            OP_HOLD:
            begin
                tag_next = tag_reg;
                pri_next = pri_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        pri_reg <= pri_next;
    end

    assign tag = tag_reg;
    assign pri = pri_reg;

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: command decode, entry count and result register.
// The queue keeps its entries in a row of cells sorted by priority, then by tag, and each
// command beat gives exactly one result beat. None, enqueue, dequeue and clear do not stall
// commands, so a new command is taken in every cycle while the result side keeps up. A
// change of priority that succeeds stalls the command side, because the row of cells makes
// one shift per cycle: the entry is removed first and then inserted again in state ST_INSERT.
// A result waiting in the output register stalls the command side only when it is not taken.
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire spq_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output spq_pkg::res_t      res
);
    import spq_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_INSERT = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic [TAG_BITS-1:0]      key_tag_reg;
    logic [PRIORITY_BITS-1:0] key_pri_reg;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    res_t                     res_reg;
    res_t                     res_next;

    logic                     accept;
    logic                     out_free;
    logic                     load;
    op_t                      op;
    logic [TAG_BITS-1:0]      key_tag;
    logic [PRIORITY_BITS-1:0] key_pri;
    logic [STAT_W-1:0]        status;
    logic                     rep_valid;
    logic [TAG_BITS-1:0]      rep_tag;
    logic [PRIORITY_BITS-1:0] rep_pri;
    logic                     full;
    logic                     empty;

    logic [TAG_BITS-1:0]      cell_tag [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_pri [CAPACITY];
    logic [TAG_BITS-1:0]      left_tag [CAPACITY];
    logic [PRIORITY_BITS-1:0] left_pri [CAPACITY];
    logic [TAG_BITS-1:0]      right_tag [CAPACITY];
    logic [PRIORITY_BITS-1:0] right_pri [CAPACITY];
    link_t                    link [CAPACITY+1];

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    assign key_tag = (state_reg == ST_INSERT) ? key_tag_reg : cmd.value_tag[TAG_BITS-1:0];
    assign key_pri = (state_reg == ST_INSERT) ? key_pri_reg :
                     cmd.priority_req[PRIORITY_BITS-1:0];

    assign link[0] = '0;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_tag[i] = '0;
                assign left_pri[i] = '0;
            end
            else
            begin : g_inner_left
                assign left_tag[i] = cell_tag[i-1];
                assign left_pri[i] = cell_pri[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_tag[i] = cell_tag[i];
                assign right_pri[i] = cell_pri[i];
            end
            else
            begin : g_inner_right
                assign right_tag[i] = cell_tag[i+1];
                assign right_pri[i] = cell_pri[i+1];
            end

            spq_cell u_cell (
                .clk       (clk),
                .op        (op),
                .occupied  (COUNT_W'(i) < count_reg),
                .key_tag   (key_tag),
                .key_pri   (key_pri),
                .left_tag  (left_tag[i]),
                .left_pri  (left_pri[i]),
                .right_tag (right_tag[i]),
                .right_pri (right_pri[i]),
                .link_in   (link[i]),
                .link_out  (link[i+1]),
                .tag       (cell_tag[i]),
                .pri       (cell_pri[i])
            );
        end
    endgenerate

    always_comb
    begin
        op         = OP_HOLD;
        state_next = state_reg;
        count_next = count_reg;
        load       = 1'b0;
        status     = ST_OK;
        rep_valid  = !empty;
        rep_tag    = cell_tag[0];
        rep_pri    = cell_pri[0];
        if (state_reg == ST_INSERT)
        begin
            if (out_free)
            begin
                op         = OP_INSERT;
                load       = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
                rep_valid  = 1'b1;
                if (link[1].ahead)
                begin
                    rep_tag = key_tag;
                    rep_pri = key_pri;
                end
            end
        end
        else if (accept)
        begin
            load = 1'b1;
            unique case (cmd.command)
                CMD_ENQUEUE:
                begin
                    if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        op         = OP_INSERT;
                        count_next = count_reg + 1'b1;
                        rep_valid  = 1'b1;
                        if (link[1].ahead)
                        begin
                            rep_tag = key_tag;
                            rep_pri = key_pri;
                        end
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        op         = OP_DEQUEUE;
                        count_next = count_reg - 1'b1;
                    end
                end
                CMD_CHANGE:
                begin
                    if (!link[CAPACITY].seen)
                    begin
                        status = ST_NOT_FOUND;
                    end
                    else if (link[CAPACITY].hit_pri < key_pri)
                    begin
                        status = ST_NOT_URGENT;
                    end
                    else
                    begin
                        op         = OP_REMOVE;
                        count_next = count_reg - 1'b1;
                        state_next = ST_INSERT;
                        load       = 1'b0;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                    rep_valid  = 1'b0;
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        res_next              = res_reg;
        res_valid_next        = res_stall ? res_valid_reg : 1'b0;
        if (load)
        begin
            res_valid_next        = 1'b1;
            res_next.status       = status;
            res_next.out_tag      = rep_valid ? TAG_W'(rep_tag) : '0;
            res_next.out_priority = rep_valid ? PRI_W'(rep_pri) : '0;
            res_next.out_valid    = rep_valid;
            res_next.entry_count  = ENTRY_W'(count_next);
            res_next.is_empty     = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            key_tag_reg <= cmd.value_tag[TAG_BITS-1:0];
            key_pri_reg <= cmd.priority_req[PRIORITY_BITS-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `SPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= COUNT_W'(CAPACITY), "entry count above capacity")
    `SPQ_ASSERT(a_insert_room, clk, rst_n, (state_reg != ST_INSERT) || !full, "reinsert with a full row")
    `SPQ_ASSERT_NEXT(a_clear_count, clk, rst_n, accept && (cmd.command == CMD_CLEAR), count_reg == '0, "clear left entries behind")
    `SPQ_ASSERT(a_insert_origin, clk, rst_n, !$rose(state_reg == ST_INSERT) || $past(accept && (cmd.command == CMD_CHANGE)), "reinsert without a change of priority")

endmodule

`default_nettype wire

/* bench/spq_checker.sv */
// Checker for the sorted priority queue: watches both channels, predicts each reply and compares.
`timescale 1ns / 1ps

module spq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  spq_pkg::cmd_t cmd,
    input  logic          res_valid,
    input  logic          res_stall,
    input  spq_pkg::res_t res,
    output int            mismatches,
    output int            outstanding,
    output int            commands_seen,
    output int            replies_checked,
    output int            refusals,
    output int            deepest
);
    import spq_pkg::*;

    localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_BITS);
    localparam logic [PRI_W-1:0] PRI_MASK = {PRI_W{1'b1}} >> (PRI_W - PRIORITY_BITS);
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
    } slot_t;

    slot_t held[$];
    res_t  awaited_replies[$];

    initial
    begin
        mismatches      = 0;
        outstanding     = 0;
        commands_seen   = 0;
        replies_checked = 0;
        refusals        = 0;
        deepest         = 0;
    end

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                   input logic [TAG_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void place_entry(input logic [TAG_W-1:0] tag,
                                        input logic [PRI_W-1:0] pri);
        int pos;
        slot_t s;
        pos = 0;
        while (pos < held.size() &&
               !(held[pos].pri > pri || (held[pos].pri == pri && tag < held[pos].tag)))
            pos++;
        s.tag = tag;
        s.pri = pri;
        held.insert(pos, s);
    endfunction

    function automatic res_t apply_command(input cmd_t c);
        res_t             r;
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        int               hit;
        bit               show_front;
        r          = '0;
        r.status   = ST_OK;
        show_front = 1'b1;
        tag        = c.value_tag & TAG_MASK;
        pri        = c.priority_req & PRI_MASK;
        case (c.command)
            CMD_ENQUEUE:
                if (held.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    place_entry(tag, pri);
            CMD_DEQUEUE:
                if (held.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.out_tag      = held[0].tag;
                    r.out_priority = held[0].pri;
                    r.out_valid    = 1'b1;
                    void'(held.pop_front());
                    show_front     = 1'b0;
                end
            CMD_CHANGE:
            begin
                hit = -1;
                for (int i = 0; i < held.size(); i++)
                    if (hit < 0 && held[i].tag == tag)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else if (held[hit].pri < pri)
                    r.status = ST_NOT_URGENT;
                else
                begin
                    held.delete(hit);
                    place_entry(tag, pri);
                end
            end
            CMD_CLEAR:
                held.delete();
            default:
                ;
        endcase
        if (show_front && held.size() > 0)
        begin
            r.out_tag      = held[0].tag;
            r.out_priority = held[0].pri;
            r.out_valid    = 1'b1;
        end
        r.entry_count = ENTRY_W'(held.size());
        r.is_empty    = (held.size() == 0);
        return r;
    endfunction

    task automatic check_reply(input res_t got);
        res_t want;
        if (awaited_replies.size() == 0)
        begin
            report_mismatch("reply with nothing awaited", got.out_tag, '0);
            return;
        end
        want = awaited_replies.pop_front();
        replies_checked++;
        if (got.status !== want.status)
            report_mismatch("status", TAG_W'(got.status), TAG_W'(want.status));
        if (got.out_tag !== want.out_tag)
            report_mismatch("out_tag", got.out_tag, want.out_tag);
        if (got.out_priority !== want.out_priority)
            report_mismatch("out_priority", TAG_W'(got.out_priority),
                            TAG_W'(want.out_priority));
        if (got.out_valid !== want.out_valid)
            report_mismatch("out_valid", TAG_W'(got.out_valid), TAG_W'(want.out_valid));
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", TAG_W'(got.entry_count),
                            TAG_W'(want.entry_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", TAG_W'(got.is_empty), TAG_W'(want.is_empty));
    endtask

    always @(posedge clk)
    begin
        res_t predicted;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_reply(res);
            if (cmd_valid && !cmd_stall)
            begin
                predicted = apply_command(cmd);
                awaited_replies.push_back(predicted);
                commands_seen++;
                if (predicted.status != ST_OK)
                    refusals++;
                if (held.size() > deepest)
                    deepest = held.size();
            end
            outstanding = awaited_replies.size();
        end
    end

endmodule

/* bench/tb.sv */
// Testbench top for the sorted priority queue: clock, reset, command stimulus, reply stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    int mismatches;
    int outstanding;
    int commands_seen;
    int replies_checked;
    int refusals;
    int deepest;

    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    logic [TAG_W-1:0] known_tags [8];

    sorted_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    spq_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .commands_seen   (commands_seen),
        .replies_checked (replies_checked),
        .refusals        (refusals),
        .deepest         (deepest)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [TAG_W-1:0] t,
                             input logic [PRI_W-1:0] p);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid          = 1'b1;
        cmd.command        = c;
        cmd.value_tag      = t;
        cmd.priority_req   = p;
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_random(input int enq_pct);
        int               roll;
        int               slot;
        logic [CMD_W-1:0] c;
        logic [TAG_W-1:0] t;
        logic [PRI_W-1:0] p;
        roll = $urandom_range(99);
        if (roll < 1)
            c = CMD_CLEAR;
        else if (roll < 2)
            c = CMD_NONE;
        else if (roll < 4)
            c = CMD_CLEAR + CMD_W'($urandom_range(1, 3));
        else if (roll < 29)
            c = CMD_CHANGE;
        else if ($urandom_range(99) < enq_pct)
            c = CMD_ENQUEUE;
        else
            c = CMD_DEQUEUE;
        slot = $urandom_range(7);
        if ($urandom_range(9) < 7)
            t = known_tags[slot];
        else
        begin
            case ($urandom_range(3))
                0: t = {$urandom, $urandom};
                1: t = TAG_W'($urandom_range(15));
                2: t = '0;
                default: t = '1;
            endcase
            if (c == CMD_ENQUEUE)
                known_tags[slot] = t;
        end
        case ($urandom_range(9))
            0: p = '0;
            1: p = '1;
            2, 3, 4: p = PRI_W'($urandom);
            default: p = PRI_W'($urandom_range(7));
        endcase
        send_beat(c, t, p);
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            known_tags[i] = TAG_W'(i + 1);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(CMD_DEQUEUE, '1, '1);
        send_beat(CMD_CHANGE, 64'd5, 16'd1);
        send_beat(CMD_NONE, 64'd9, 16'd9);
        send_beat(CMD_ENQUEUE, '0, '1);
        send_beat(CMD_ENQUEUE, '1, '0);
        send_beat(CMD_ENQUEUE, 64'd7, 16'd3);
        send_beat(CMD_ENQUEUE, 64'd3, 16'd3);
        send_beat(CMD_ENQUEUE, 64'd7, 16'd3);
        send_beat(CMD_CHANGE, 64'd7, 16'd3);
        send_beat(CMD_CHANGE, 64'd3, 16'd9);
        send_beat(CMD_CHANGE, '0, '0);
        send_beat(CMD_CHANGE, 64'd42, '0);
        send_beat(CMD_CLEAR + CMD_W'(1), '1, '1);
        send_beat(CMD_CLEAR + CMD_W'(2), '0, '0);
        send_beat(CMD_CLEAR + CMD_W'(3), 64'd3, 16'd3);
        send_beat(CMD_DEQUEUE, '0, '0);
        send_beat(CMD_DEQUEUE, '0, '0);
        send_beat(CMD_CLEAR, '0, '0);
        send_beat(CMD_DEQUEUE, '0, '0);
        send_beat(CMD_ENQUEUE, '1, '1);
        send_beat(CMD_CHANGE, '1, '0);
        send_beat(CMD_DEQUEUE, '0, '0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random((ph % 3 == 0) ? 75 : ((ph % 3 == 1) ? 50 : 30));
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d commands and %0d checked replies, %0d of them refused",
                 commands_seen, replies_checked, refusals);
        $display("queue depth reached %0d of %0d entries", deepest, CAPACITY);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
